// ===== rtl/sm3_pkg.sv =====
package sm3_pkg;

	typedef enum logic [1:0] {
		PAD_NONE,
		PAD_WORD,
		PAD_FLUSH
	} pad_t;

	// queued block word with its control
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} qent_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} back_state_t;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [255:0] IV = {
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ===== rtl/sm3_front.sv =====
// accepts message words, builds padded block words, tracks bit length
module sm3_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     data_word,
	input  logic [2:0]      byte_count,
	input  logic            last_word,
	output logic            q_valid,
	input  logic            q_ready,
	output sm3_pkg::qent_t  q_data
);
	sm3_pkg::pad_t pad_q;
	logic [63:0] len_q;
	logic [3:0]  pos_q;
	logic        wrap_q;
	logic [2:0]  n;
	logic [31:0] mask, tail;
	logic [63:0] total;
	logic        put;

	assign in_ready = (pad_q == sm3_pkg::PAD_NONE) && q_ready;
	assign put = q_valid && q_ready;
	assign n = (!last_word) ? 3'd4 : (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign total = len_q + {58'd0, n, 3'b000};

	always_comb begin
		mask = 32'hFFFFFFFF;
		tail = 32'h0;
		unique case (n)
			3'd0: begin mask = 32'h0;        tail = 32'h80000000; end
			3'd1: begin mask = 32'hFF000000; tail = 32'h00800000; end
			3'd2: begin mask = 32'hFFFF0000; tail = 32'h00008000; end
			3'd3: begin mask = 32'hFFFFFF00; tail = 32'h00000080; end
			default: begin mask = 32'hFFFFFFFF; tail = 32'h0; end
		endcase
	end

	// wrap_q: pad word took slot 14, slot 15 is zero and the length goes to the next block
	always_comb begin
		q_valid = 1'b0;
		q_data  = '0;
		unique case (pad_q)
			sm3_pkg::PAD_NONE: begin
				q_valid = in_valid;
				q_data.word = (data_word & mask) | tail;
			end
			sm3_pkg::PAD_WORD: begin
				q_valid = 1'b1;
				q_data.word = 32'h80000000;
			end
			sm3_pkg::PAD_FLUSH: begin
				q_valid = 1'b1;
				q_data.word = wrap_q ? 32'h0 :
					(pos_q == 4'd14) ? len_q[63:32] :
					(pos_q == 4'd15) ? len_q[31:0] : 32'h0;
				q_data.last = !wrap_q && (pos_q == 4'd15);
			end
			default: q_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= sm3_pkg::PAD_NONE;
			len_q <= '0;
			pos_q <= '0;
			wrap_q <= 1'b0;
		end else if (put) begin
			pos_q <= pos_q + 4'd1;
			unique case (pad_q)
				sm3_pkg::PAD_NONE: begin
					len_q <= total;
					if (last_word) begin
						pad_q <= (n == 3'd4) ? sm3_pkg::PAD_WORD : sm3_pkg::PAD_FLUSH;
						if (n != 3'd4)
							wrap_q <= (pos_q == 4'd14);
					end
				end
				sm3_pkg::PAD_WORD: begin
					pad_q <= sm3_pkg::PAD_FLUSH;
					wrap_q <= (pos_q == 4'd14);
				end
				sm3_pkg::PAD_FLUSH: if (wrap_q) begin
					wrap_q <= 1'b0;
				end else if (pos_q == 4'd15) begin
					pad_q <= sm3_pkg::PAD_NONE;
					len_q <= '0;
				end
				default: pad_q <= sm3_pkg::PAD_NONE;
			endcase
		end
	end
endmodule

// ===== rtl/sm3_fifo.sv =====
// short queue between front and back
module sm3_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  sm3_pkg::qent_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output sm3_pkg::qent_t rd_data
);
	localparam int AW = $clog2(DEPTH);
	sm3_pkg::qent_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != DEPTH[AW:0];
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
		end
	end
endmodule

// ===== rtl/sm3_back.sv =====
// block gather, 64-round compression, digest emission
module sm3_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  sm3_pkg::qent_t q_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    digest_word,
	output logic [2:0]     word_index,
	output logic           digest_last
);
	sm3_pkg::back_state_t st_q, st_d;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] r_q [8];
	logic [3:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        lastblk_q;
	logic        take;
	logic [31:0] wnew, wj, wx, t, a12, ss1, ss2, ff, gg, tt1, tt2;

	assign q_ready = (st_q == sm3_pkg::ST_LOAD);
	assign take = q_valid && q_ready;
	assign out_valid = (st_q == sm3_pkg::ST_EMIT);
	assign digest_word = v_q[idx_q];
	assign word_index = idx_q;
	assign digest_last = (idx_q == 3'd7);

	// window w_q[0] holds W[j]; shifts one each round
	always_comb begin
		wnew = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
			^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
		wj = w_q[0];
		wx = wj ^ w_q[4];
		t = rnd_q[5:4] == 2'b00 ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
		a12 = sm3_pkg::rotl(r_q[0], 5'd12);
		ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::rotl(t, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q[5:4] == 2'b00) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + wx;
		tt2 = gg + r_q[7] + ss1 + wj;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sm3_pkg::ST_LOAD:  if (take && fill_q == 4'd15) st_d = sm3_pkg::ST_ROUND;
			sm3_pkg::ST_ROUND: if (rnd_q == 6'd63) st_d = sm3_pkg::ST_FOLD;
			sm3_pkg::ST_FOLD:  st_d = lastblk_q ? sm3_pkg::ST_EMIT : sm3_pkg::ST_LOAD;
			sm3_pkg::ST_EMIT:  if (out_ready && idx_q == 3'd7) st_d = sm3_pkg::ST_LOAD;
			default: st_d = sm3_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sm3_pkg::ST_LOAD;
			fill_q <= '0;
			rnd_q <= '0;
			idx_q <= '0;
			lastblk_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= sm3_pkg::IV[255-32*i -: 32];
				r_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			unique case (st_q)
				sm3_pkg::ST_LOAD: if (take) begin
					fill_q <= fill_q + 4'd1;
					lastblk_q <= q_data.last;
					if (fill_q == 4'd15) begin
						rnd_q <= '0;
						for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
					end
				end
				sm3_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					r_q[3] <= r_q[2];
					r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
					r_q[1] <= r_q[0];
					r_q[0] <= tt1;
					r_q[7] <= r_q[6];
					r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
					r_q[5] <= r_q[4];
					r_q[4] <= sm3_pkg::p0(tt2);
				end
				sm3_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) v_q[i] <= v_q[i] ^ r_q[i];
					idx_q <= '0;
				end
				sm3_pkg::ST_EMIT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7)
						for (int i = 0; i < 8; i++) v_q[i] <= sm3_pkg::IV[255-32*i -: 32];
				end
				default: ;
			endcase
		end
	end

	// message window: loads in order, then rolls during rounds
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= q_data.word;
		end else if (st_q == sm3_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end
endmodule

// ===== rtl/sm3_hash_engine.sv =====
// sm3 hash engine, 256-bit digest
// input channel s_axis: one big-endian message word per transaction;
//   byte_count gives valid leading bytes (only below four on the last word),
//   tlast marks the final word of a message
// output channel m_axis: eight digest words per message, word 0 first,
//   tlast on the eighth, tuser gives the word index
// the front stage applies 0x80, zero fill and the 64-bit bit length and
//   pushes block words into a four-entry queue; the back stage gathers
//   sixteen words and runs one sm3 round per clock
// per block: the back stage loads sixteen words, runs 64 rounds and one fold,
//   and takes no further block words until it is back in loading; the round
//   loop in the back stage sets the pace
// after the last word, the padding block(s) load and compress, then
//   digest words stream out one per cycle as the receiver takes them
// a stalled receiver holds the back stage in emission; the queue then fills
//   and s_axis_tready drops until the digest has gone
// reset returns chain value to the standard iv and clears length and fill;
//   no clearing pass is needed
module sm3_hash_engine #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero fill
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word[31:0]
	output logic [2:0]  m_axis_tuser,  // word_index[2:0]
	output logic        m_axis_tlast
);
	// transaction path front -> queue -> back
	logic           fq_valid, fq_ready, qb_valid, qb_ready;
	sm3_pkg::qent_t fq_data, qb_data;

	sm3_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.data_word(s_axis_tdata[31:0]), .byte_count(s_axis_tdata[34:32]),
		.last_word(s_axis_tlast),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	sm3_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
	);

	sm3_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.digest_word(m_axis_tdata), .word_index(m_axis_tuser),
		.digest_last(m_axis_tlast)
	);
endmodule

// ===== rtl/sm3_checker.sv =====
// port-level checks for the hash engine
module sm3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
		else $error("tlast not on word seven");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
		else $error("digest words not consecutive");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled digest changed");
endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);

// ===== tb/tb_sm3_hash_engine.sv =====
`timescale 1ns / 1ps

module tb_sm3_hash_engine;

	localparam logic [31:0] SM3_IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};
	localparam logic [255:0] ABC_DIGEST = {
		32'h66c7f0f4, 32'h62eeedd9, 32'hd1f2d46b, 32'hdc10e4e2,
		32'h4167c487, 32'h5cf2f7a2, 32'h297da02b, 32'h8f4ba8e0
	};
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 340;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  cnt;
		logic        last;
	} msg_word_t;

	typedef struct {
		logic [31:0] digest;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// software view of the hash state
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [63:0] msg_bits;
	int          fill_words;

	digest_word_t digest_q[$];
	msg_word_t    stim_q[$];
	int errors;
	int cycles;
	int digests_seen;
	int hold_off;     // long receiver stall request, counted down in the sink
	bit quiet;        // no idling in the last stretch

	sm3_hash_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		n = n % 32;
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	// 64 rounds over the buffered block, folded into the chain value
	task automatic sm3_compress();
		logic [31:0] w [68];
		logic [31:0] r [8];
		logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, t, x;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 68; i++) begin
			x = w[i-16] ^ w[i-9] ^ rol(w[i-3], 15);
			w[i] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[i-13], 7) ^ w[i-6];
		end
		for (int i = 0; i < 8; i++) r[i] = chain[i];
		for (int j = 0; j < 64; j++) begin
			t = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
			a12 = rol(r[0], 12);
			ss1 = rol(a12 + r[4] + rol(t, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = r[0] ^ r[1] ^ r[2];
				gg = r[4] ^ r[5] ^ r[6];
			end else begin
				ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
				gg = (r[4] & r[5]) | (~r[4] & r[6]);
			end
			tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + r[7] + ss1 + w[j];
			r[3] = r[2];
			r[2] = rol(r[1], 9);
			r[1] = r[0];
			r[0] = tt1;
			r[7] = r[6];
			r[6] = rol(r[5], 19);
			r[5] = r[4];
			r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
		end
		for (int i = 0; i < 8; i++) chain[i] ^= r[i];
	endtask

	task automatic push_block_word(logic [31:0] v);
		blk[fill_words] = v;
		fill_words = (fill_words + 1) % 16;
		if (fill_words == 0) sm3_compress();
	endtask

	task automatic hash_absorb(msg_word_t m);
		int n;
		logic [63:0] total;
		logic [31:0] v;
		if (!m.last) begin
			msg_bits += 64'd32;
			push_block_word(m.word);
			return;
		end
		n = (m.cnt > 3'd4) ? 4 : int'(m.cnt);
		msg_bits += 64'(8 * n);
		total = msg_bits;
		if (n == 4) begin
			push_block_word(m.word);
			push_block_word(32'h80000000);
		end else begin
			v = (n == 0) ? 32'h0 : (m.word & (32'hFFFFFFFF << (32 - 8 * n)));
			v |= 32'h80 << (24 - 8 * n);
			push_block_word(v);
		end
		while (fill_words != 14) push_block_word(32'h0);
		push_block_word(total[63:32]);
		push_block_word(total[31:0]);
		for (int k = 0; k < 8; k++)
			digest_q.push_back('{chain[k], 3'(k), k == 7});
		for (int k = 0; k < 8; k++) chain[k] = SM3_IV[k];
		msg_bits = '0;
		fill_words = 0;
	endtask

	// sender: drives one transaction and predicts on acceptance
	task automatic send_word(msg_word_t m);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, m.cnt, m.word};
		s_axis_tlast  <= m.last;
		do @(posedge clk); while (!s_axis_tready);
		hash_absorb(m);
	endtask

	// sender goes idle after its last transaction
	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off      <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 4) != 0);
		end
	end

	// checker
	always @(posedge clk) begin
		digest_word_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("digest transaction with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				e = digest_q.pop_front();
				digests_seen++;
				if (m_axis_tdata !== e.digest) begin
					$error("digest_word expected %h actual %h", e.digest, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== e.idx) begin
					$error("word_index expected %0d actual %0d", e.idx, m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("digest_last expected %0d actual %0d", e.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_message(int words, int cnt);
		for (int i = 0; i < words - 1; i++)
			stim_q.push_back('{$urandom, 3'($urandom_range(0, 7)), 1'b0});
		stim_q.push_back('{$urandom, 3'(cnt), 1'b1});
	endtask

	initial begin
		msg_word_t m;
		int sent;
		errors = 0;
		cycles = 0;
		digests_seen = 0;
		hold_off = 0;
		quiet = 0;
		msg_bits = '0;
		fill_words = 0;
		for (int k = 0; k < 8; k++) chain[k] = SM3_IV[k];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;

		// directed rows: "abc" gives the published digest, the rest go to the predictor
		stim_q.push_back('{32'h61626300, 3'd3, 1'b1});
		stim_q.push_back('{32'hFFFFFFFF, 3'd0, 1'b1});           // empty last word
		stim_q.push_back('{32'hFFFFFFFF, 3'd1, 1'b1});           // trailing bytes dropped
		stim_q.push_back('{32'hFFFFFFFF, 3'd2, 1'b1});
		stim_q.push_back('{32'h00000000, 3'd4, 1'b1});
		stim_q.push_back('{32'hFFFFFFFF, 3'd7, 1'b1});           // count above four
		stim_q.push_back('{32'hA5A5A5A5, 3'd5, 1'b1});
		for (int i = 0; i < 14; i++)                              // short words not last
			stim_q.push_back('{32'hFFFFFFFF, 3'(i % 4), 1'b0});
		stim_q.push_back('{32'h12345678, 3'd3, 1'b1});           // length word spills a block
		for (int i = 0; i < 15; i++)
			stim_q.push_back('{32'h0, 3'd6, 1'b0});
		stim_q.push_back('{32'hDEADBEEF, 3'd4, 1'b1});           // full block then padding

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first row has a fixed answer: sm3("abc")
		m = stim_q.pop_front();
		send_word(m);
		for (int k = 0; k < 8; k++) begin
			if (digest_q[k].digest !== ABC_DIGEST[255 - 32 * k -: 32]) begin
				$error("digest_word row abc word %0d expected %h predicted %h", k,
					ABC_DIGEST[255 - 32 * k -: 32], digest_q[k].digest);
				errors++;
			end
		end
		while (stim_q.size() > 0) send_word(stim_q.pop_front());
		stop_sending();

		// sender pauses until every digest has drained
		wait (digest_q.size() == 0);

		// random messages: mostly short, a few spanning several blocks
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40)
			                                  : $urandom_range(1, 6);
			add_message(len, $urandom_range(0, 7));
			sent += len;
		end
		sent = 0;
		while (stim_q.size() > 0) begin
			if (sent == 40) hold_off = 300;   // receiver stalls, input must back up
			if (sent == RANDOM_WORDS - 60) quiet = 1;
			send_word(stim_q.pop_front());
			sent++;
		end
		stop_sending();

		wait (digest_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d random words plus directed rows, checked %0d digest words",
			sent, digests_seen);
		$display("covered byte counts 0..7, block-boundary padding, long receiver stall");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sm3_hash_engine.f =====
rtl/sm3_pkg.sv
rtl/sm3_front.sv
rtl/sm3_fifo.sv
rtl/sm3_back.sv
rtl/sm3_hash_engine.sv
rtl/sm3_checker.sv
tb/tb_sm3_hash_engine.sv
